// File: sv/bounded_stack_search_minmax_defines.svh
// Assertion macros shared by the stack design.
`ifndef BOUNDED_STACK_SEARCH_MINMAX_DEFINES_SVH
`define BOUNDED_STACK_SEARCH_MINMAX_DEFINES_SVH

// Property checked on every rising edge of clk, off while rst is high.
`define BSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge of clk.
`define BSS_ASSERT_NEVER(lbl, cond, msg) \
  `BSS_ASSERT(lbl, !(cond), msg)

`endif

// File: sv/bss_pkg.sv
package bss_pkg;

  // Width of one stored word.
  localparam int WORD_W = 32;

  // Default number of stack entries.
  localparam int DEPTH_DEFAULT = 64;

  // Operation codes carried by an item.
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_MIN    = 3'd4,
    OP_MAX    = 3'd5
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic step;      // read data holds a stored entry this cycle
    logic first;     // that entry is the first of the scan
    logic want_max;  // track the greatest rather than the least word
  } bss_ctl_t;

endpackage

// File: sv/bss_mem.sv
module bss_mem #(
  parameter int DEPTH = bss_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [bss_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]                   raddr,
  output logic signed [bss_pkg::WORD_W-1:0] rdata
);

  logic signed [bss_pkg::WORD_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bss_alu.sv
module bss_alu (
  input  logic                              clk,
  input  bss_pkg::bss_ctl_t                 ctl,
  input  logic signed [bss_pkg::WORD_W-1:0] data,
  input  logic signed [bss_pkg::WORD_W-1:0] key,
  output logic signed [bss_pkg::WORD_W-1:0] best,
  output logic                              hit
);

  logic better;
  logic equal;

  // One signed compare for the extreme and one equality compare for the key.
  assign better = ctl.want_max ? (data > best) : (data < best);
  assign equal  = (data == key);

  // The first entry seeds both trackers; later entries update them.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (ctl.first) begin
        best <= data;
        hit  <= equal;
      end else begin
        if (better) begin
          best <= data;
        end
        hit <= hit | equal;
      end
    end
  end

endmodule

// File: sv/bounded_stack_search_minmax.sv
// Push and pop take one item per cycle while the sequencer is idle; peek returns the top entry from S_PEEK.
// Search, minimum and maximum read one stored entry per cycle through the single
// memory read port, then pass through S_FIN and S_DONE before the result.
// The result strobe is registered in S_DONE after the last step and cannot be stalled.
// Synchronous reset empties the stack and idles the sequencer; entries keep old data.
`include "bounded_stack_search_minmax_defines.svh"

module bounded_stack_search_minmax #(
  parameter int DEPTH = bss_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        kind,
  input  logic signed [bss_pkg::WORD_W-1:0] value,
  output logic                              strobe,
  output logic [1:0]                        status,
  output logic signed [bss_pkg::WORD_W-1:0] result_value,
  output logic                              found
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PEEK = 5'b00010,
    S_SCAN = 5'b00100,
    S_FIN  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                            state;
  logic [CW-1:0]                     fill;
  logic [CW-1:0]                     fill_m1;
  logic [AW-1:0]                     idx;
  logic                              vld;
  logic                              first;
  bss_pkg::kind_t                    op;
  bss_pkg::kind_t                    kind_in;
  logic signed [bss_pkg::WORD_W-1:0] key;
  logic                              accept;
  logic                              is_full;
  logic                              is_empty;
  logic                              last_idx;
  logic                              we;
  logic [AW-1:0]                     raddr;
  logic signed [bss_pkg::WORD_W-1:0] rdata;
  logic signed [bss_pkg::WORD_W-1:0] best;
  logic                              scan_hit;
  bss_pkg::bss_ctl_t                 ctl;

  assign kind_in  = bss_pkg::kind_t'(kind);
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (fill == CW'(DEPTH));
  assign is_empty = (fill == '0);
  assign fill_m1  = fill - 1'b1;
  assign last_idx = (CW'(idx) == fill_m1);
  assign we       = accept && (kind_in == bss_pkg::OP_PUSH) && !is_full;

  // Read address: the top entry when idle, the scan index otherwise.
  assign raddr = (state == S_IDLE) ? fill_m1[AW-1:0] : idx;

  // Scan unit control follows the registered read data.
  assign ctl.step     = vld;
  assign ctl.first    = first;
  assign ctl.want_max = (op == bss_pkg::OP_MAX);

  bss_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (fill[AW-1:0]),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

  bss_alu u_alu (
    .clk  (clk),
    .ctl  (ctl),
    .data (rdata),
    .key  (key),
    .best (best),
    .hit  (scan_hit)
  );

  // Item payload is held for the length of a scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= kind_in;
      key <= value;
    end
    if (state == S_SCAN) begin
      first <= (idx == '0);
    end
  end

  // Sequencer, fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      idx    <= '0;
      vld    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      vld    <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (start) begin
            status       <= bss_pkg::ST_OK;
            result_value <= '0;
            found        <= 1'b0;
            unique case (kind_in)
              bss_pkg::OP_PUSH: begin
                strobe <= 1'b1;
                if (is_full) begin
                  status <= bss_pkg::ST_FULL;
                end else begin
                  fill <= fill + 1'b1;
                end
              end
              bss_pkg::OP_POP: begin
                strobe <= 1'b1;
                if (is_empty) begin
                  status <= bss_pkg::ST_EMPTY;
                end else begin
                  fill <= fill_m1;
                end
              end
              bss_pkg::OP_PEEK: begin
                if (is_empty) begin
                  strobe <= 1'b1;
                  status <= bss_pkg::ST_EMPTY;
                end else begin
                  state <= S_PEEK;
                end
              end
              bss_pkg::OP_SEARCH: begin
                if (is_empty) begin
                  strobe <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              bss_pkg::OP_MIN, bss_pkg::OP_MAX: begin
                if (is_empty) begin
                  strobe <= 1'b1;
                  status <= bss_pkg::ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end
        S_PEEK: begin
          strobe       <= 1'b1;
          result_value <= rdata;
          state        <= S_IDLE;
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (last_idx) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          strobe <= 1'b1;
          if (op == bss_pkg::OP_SEARCH) begin
            found <= scan_hit;
          end else begin
            result_value <= best;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BSS_ASSERT(a_push_grows, (accept && we) |=> (fill == $past(fill) + 1'b1), "bad push count")
  `BSS_ASSERT(a_full_status, (strobe && status == bss_pkg::ST_FULL) |-> is_full, "false full")
  `BSS_ASSERT(a_empty_status, (strobe && status == bss_pkg::ST_EMPTY) |-> is_empty, "false empty")
  `BSS_ASSERT_NEVER(a_scan_empty, (state == S_SCAN) && is_empty, "scan on empty stack")
  `BSS_ASSERT(a_scan_ends, (state == S_FIN) |=> (state == S_DONE) && !vld, "scan tail out of order")

endmodule
